// File: design/wwh_pkg.sv
// shared types, constants and helpers for the whitespace word hash tokenizer
package wwh_pkg;

  // fnv-1a constants
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // token numbers
  localparam logic [21:0] WORD_BASE = 22'd10;
  localparam logic [21:0] NL_TOKEN  = 22'd13;
  localparam logic [21:0] EOS_TOKEN = 22'd2;

  // vocabulary clamp limits
  localparam logic [22:0] VOCAB_MIN = 23'd11;
  localparam logic [22:0] VOCAB_MAX = 23'd4194304;

  // separator bytes
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_NL    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_TAB   = 8'h09;

  // configuration reset values and port width
  localparam logic [22:0] VOCAB_RESET = 23'd32000;
  localparam logic [15:0] MAX_RESET   = 16'd512;
  localparam int          CFG_DATA_W  = 23;

  // default depth of the command queue
  localparam int QUEUE_DEPTH_DEF = 4;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_VOCAB_SIZE = 2'd0,
    CFG_MAX_TOKENS = 2'd1,
    CFG_ADD_EOS    = 2'd2
  } cfg_index_t;

  // result slots produced by one request, in output order
  localparam int SLOT_WORD  = 0;
  localparam int SLOT_NL    = 1;
  localparam int SLOT_EOS   = 2;
  localparam int SLOT_EMPTY = 3;
  localparam int SLOT_N     = 4;

  // input request
  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       end_of_text;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [21:0] token_id;
    logic        token_valid;
    logic        run_last;
    logic        text_done;
    logic [15:0] token_count;
  } out_item_t;

  // command from front to back
  typedef struct packed {
    logic        is_word;
    logic [31:0] value;
    logic        token_valid;
    logic        run_last;
    logic        text_done;
    logic [15:0] token_count;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  // word separator test
  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == BYTE_SPACE) || (b == BYTE_NL) || (b == BYTE_CR) || (b == BYTE_TAB);
  endfunction

endpackage

// File: design/wwh_queue.sv
// small command queue between the front and back ends
module wwh_queue #(
  parameter int DEPTH = wwh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  wwh_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output wwh_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  wwh_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // no overflow or underflow
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> !empty)
    else $error("queue read while empty");

endmodule

// File: design/wwh_front.sv
// front end: takes requests, hashes words, tracks the token limit, issues commands
module wwh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wwh_pkg::in_item_t in_data,
  input  logic [15:0]       max_tokens,
  input  logic              add_eos,
  output logic              q_wr_en,
  output wwh_pkg::cmd_t     q_wr_data,
  input  logic              q_full
);

  // text state
  logic [31:0] hash_r, hash_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        lim_r, lim_nxt;

  // commands still to issue for the last request
  logic [wwh_pkg::SLOT_N-1:0] pend_r, pend_nxt;
  logic [31:0] cmd_hash_r, cmd_hash_nxt;
  logic [15:0] cnt_word_r, cnt_word_nxt;
  logic [15:0] cnt_nl_r, cnt_nl_nxt;
  logic [15:0] cnt_end_r, cnt_end_nxt;
  logic        eot_r, eot_nxt;

  logic        accept;
  logic        is_sp, is_nl, drop, byte_ok, word_byte;
  logic [16:0] cnt_inc;
  logic        emit_w1, emit_nl, emit_w2, emit_eos, emit_empty;
  logic [15:0] cnt_a, cnt_b, cnt_c, cnt_d;
  logic [31:0] hash_mul, hash_a;
  logic        pend_a, lim_a;
  logic [wwh_pkg::SLOT_N-1:0] sel, pend_left;

  assign in_ready = (pend_r == '0);
  assign accept   = in_valid && in_ready;

  // byte classification and limit checks
  always_comb begin
    is_sp     = wwh_pkg::is_space(in_data.text_byte);
    is_nl     = (in_data.text_byte == wwh_pkg::BYTE_NL);
    cnt_inc   = {1'b0, cnt_r} + 17'd1;
    drop      = lim_r || (cnt_inc >= {1'b0, max_tokens});
    byte_ok   = in_data.byte_valid && !drop;
    word_byte = byte_ok && !is_sp;
    hash_mul  = 32'((hash_r ^ {24'd0, in_data.text_byte}) * wwh_pkg::FNV_PRIME);

    emit_w1 = byte_ok && is_sp && pending_r;
    cnt_a   = cnt_r + {15'd0, emit_w1};
    emit_nl = byte_ok && is_nl && (cnt_a < max_tokens);
    cnt_b   = cnt_a + {15'd0, emit_nl};

    if (word_byte) begin
      hash_a = hash_mul;
      pend_a = 1'b1;
    end else if (byte_ok) begin
      hash_a = wwh_pkg::FNV_BASIS;
      pend_a = 1'b0;
    end else begin
      hash_a = hash_r;
      pend_a = pending_r;
    end
    lim_a = lim_r || (in_data.byte_valid && drop);

    emit_w2    = in_data.end_of_text && pend_a && !lim_a
                 && (({1'b0, cnt_b} + 17'd1) < {1'b0, max_tokens});
    cnt_c      = cnt_b + {15'd0, emit_w2};
    emit_eos   = in_data.end_of_text && add_eos && (cnt_c < max_tokens);
    cnt_d      = cnt_c + {15'd0, emit_eos};
    emit_empty = in_data.end_of_text && !(emit_w1 || emit_nl || emit_w2 || emit_eos);
  end

  // lowest pending slot goes out first
  always_comb begin
    sel = pend_r & (~pend_r + 1'b1);
    pend_left = pend_r & ~sel;
    q_wr_en = (pend_r != '0) && !q_full;
    q_wr_data.is_word     = sel[wwh_pkg::SLOT_WORD];
    q_wr_data.token_valid = !sel[wwh_pkg::SLOT_EMPTY];
    q_wr_data.run_last    = (pend_left == '0);
    q_wr_data.text_done   = (pend_left == '0) && eot_r;
    if (sel[wwh_pkg::SLOT_WORD]) begin
      q_wr_data.value       = cmd_hash_r;
      q_wr_data.token_count = cnt_word_r;
    end else if (sel[wwh_pkg::SLOT_NL]) begin
      q_wr_data.value       = {10'd0, wwh_pkg::NL_TOKEN};
      q_wr_data.token_count = cnt_nl_r;
    end else if (sel[wwh_pkg::SLOT_EOS]) begin
      q_wr_data.value       = {10'd0, wwh_pkg::EOS_TOKEN};
      q_wr_data.token_count = cnt_end_r;
    end else begin
      q_wr_data.value       = '0;
      q_wr_data.token_count = cnt_end_r;
    end
  end

  // next text state and command slots
  always_comb begin
    hash_nxt     = hash_r;
    pending_nxt  = pending_r;
    cnt_nxt      = cnt_r;
    lim_nxt      = lim_r;
    pend_nxt     = pend_r;
    cmd_hash_nxt = cmd_hash_r;
    cnt_word_nxt = cnt_word_r;
    cnt_nl_nxt   = cnt_nl_r;
    cnt_end_nxt  = cnt_end_r;
    eot_nxt      = eot_r;
    if (q_wr_en) begin
      pend_nxt = pend_left;
    end
    if (accept) begin
      pend_nxt[wwh_pkg::SLOT_WORD]  = emit_w1 || emit_w2;
      pend_nxt[wwh_pkg::SLOT_NL]    = emit_nl;
      pend_nxt[wwh_pkg::SLOT_EOS]   = emit_eos;
      pend_nxt[wwh_pkg::SLOT_EMPTY] = emit_empty;
      cmd_hash_nxt = emit_w1 ? hash_r : hash_a;
      cnt_word_nxt = emit_w1 ? cnt_a : cnt_c;
      cnt_nl_nxt   = cnt_b;
      cnt_end_nxt  = cnt_d;
      eot_nxt      = in_data.end_of_text;
      if (in_data.end_of_text) begin
        hash_nxt    = wwh_pkg::FNV_BASIS;
        pending_nxt = 1'b0;
        cnt_nxt     = '0;
        lim_nxt     = 1'b0;
      end else begin
        hash_nxt    = hash_a;
        pending_nxt = pend_a;
        cnt_nxt     = cnt_b;
        lim_nxt     = lim_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r    <= wwh_pkg::FNV_BASIS;
      pending_r <= 1'b0;
      cnt_r     <= '0;
      lim_r     <= 1'b0;
      pend_r    <= '0;
      eot_r     <= 1'b0;
    end else begin
      hash_r    <= hash_nxt;
      pending_r <= pending_nxt;
      cnt_r     <= cnt_nxt;
      lim_r     <= lim_nxt;
      pend_r    <= pend_nxt;
      eot_r     <= eot_nxt;
    end
  end

  // command payload
  always_ff @(posedge clk) begin
    cmd_hash_r <= cmd_hash_nxt;
    cnt_word_r <= cnt_word_nxt;
    cnt_nl_r   <= cnt_nl_nxt;
    cnt_end_r  <= cnt_end_nxt;
  end

  // end of text leaves the text state cleared
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) && eot_r |-> !pending_r && (cnt_r == '0) && !lim_r)
    else $error("text state not cleared after end of text");

endmodule

// File: design/wwh_back.sv
// back end: reduces word hashes modulo the vocabulary span and drives the results
module wwh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  wwh_pkg::cmd_t      q_rd_data,
  output logic               q_rd_en,
  input  logic [22:0]        vocab_size,
  output logic               out_valid,
  input  logic               out_ready,
  output wwh_pkg::out_item_t out_data
);

  wwh_pkg::back_state_t state_r, state_nxt;
  wwh_pkg::cmd_t        cmd_r;
  logic [31:0]          dvd_r;
  logic [21:0]          rem_r, rem_nxt;
  logic [21:0]          d_r, d_nxt;
  logic [4:0]           step_r;
  logic                 out_valid_r, out_valid_nxt;
  wwh_pkg::out_item_t   out_data_r, out_data_nxt;

  logic       load_out, div_step, last_step;
  logic [22:0] vclamp, trial;

  assign last_step = (step_r == 5'd31);

  // divisor from the clamped vocabulary size
  always_comb begin
    if (vocab_size < wwh_pkg::VOCAB_MIN) begin
      vclamp = wwh_pkg::VOCAB_MIN;
    end else if (vocab_size > wwh_pkg::VOCAB_MAX) begin
      vclamp = wwh_pkg::VOCAB_MAX;
    end else begin
      vclamp = vocab_size;
    end
    d_nxt = 22'(vclamp - {1'b0, wwh_pkg::WORD_BASE});
  end

  // one restoring division step
  always_comb begin
    trial   = {rem_r, dvd_r[31]};
    rem_nxt = (trial >= {1'b0, d_r}) ? 22'(trial - {1'b0, d_r}) : trial[21:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wwh_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_rd_data.is_word ? wwh_pkg::B_DIV : wwh_pkg::B_DONE;
        end
      end
      wwh_pkg::B_DIV: begin
        if (last_step) begin
          state_nxt = wwh_pkg::B_DONE;
        end
      end
      wwh_pkg::B_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = wwh_pkg::B_IDLE;
        end
      end
      default: state_nxt = wwh_pkg::B_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_rd_en  = 1'b0;
    div_step = 1'b0;
    load_out = 1'b0;
    case (state_r)
      wwh_pkg::B_IDLE: q_rd_en  = !q_empty;
      wwh_pkg::B_DIV:  div_step = 1'b1;
      wwh_pkg::B_DONE: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.token_valid = cmd_r.token_valid;
      out_data_nxt.run_last    = cmd_r.run_last;
      out_data_nxt.text_done   = cmd_r.text_done;
      out_data_nxt.token_count = cmd_r.token_count;
      if (cmd_r.is_word) begin
        out_data_nxt.token_id = rem_r + wwh_pkg::WORD_BASE;
      end else begin
        out_data_nxt.token_id = cmd_r.value[21:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wwh_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command and divider datapath
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (q_rd_en) begin
      cmd_r  <= q_rd_data;
      dvd_r  <= q_rd_data.value;
      rem_r  <= '0;
      d_r    <= d_nxt;
      step_r <= '0;
    end else if (div_step) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[30:0], 1'b0};
      step_r <= step_r + 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // remainder stays below the divisor and only words divide
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wwh_pkg::B_DIV) |-> (rem_r < d_r))
    else $error("remainder not below divisor");
  a_div_only_words: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wwh_pkg::B_DIV) |-> cmd_r.is_word)
    else $error("division started for a fixed token");

endmodule

// File: design/whitespace_word_hash_tokenizer.sv
// Fixed tokens (newline, end, empty end) skip the divider; a word token passes the 32-step
// bit-serial modulo in the back end.
// Flow: the front end takes a new request only once every command of the last one is queued,
// and the back end works one command at a time, word tokens through the divider loop.
// Reset: synchronous active-low; configuration returns to 32000 / 512 / 0 and text state
// clears at once, no clearing pass.
module whitespace_word_hash_tokenizer #(
  parameter int QUEUE_DEPTH = wwh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wwh_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wwh_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [wwh_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [22:0] vocab_r, vocab_nxt;
  logic [15:0] max_r, max_nxt;
  logic        eos_r, eos_nxt;

  logic          q_wr_en, q_full, q_rd_en, q_empty;
  wwh_pkg::cmd_t q_wr_data, q_rd_data;

  // configuration register writes
  always_comb begin
    vocab_nxt = vocab_r;
    max_nxt   = max_r;
    eos_nxt   = eos_r;
    if (cfg_we) begin
      case (cfg_index)
        wwh_pkg::CFG_VOCAB_SIZE: vocab_nxt = cfg_wdata[22:0];
        wwh_pkg::CFG_MAX_TOKENS: max_nxt   = cfg_wdata[15:0];
        wwh_pkg::CFG_ADD_EOS:    eos_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vocab_r <= wwh_pkg::VOCAB_RESET;
      max_r   <= wwh_pkg::MAX_RESET;
      eos_r   <= 1'b0;
    end else begin
      vocab_r <= vocab_nxt;
      max_r   <= max_nxt;
      eos_r   <= eos_nxt;
    end
  end

  // request intake and word hashing
  wwh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .max_tokens (max_r),
    .add_eos    (eos_r),
    .q_wr_en    (q_wr_en),
    .q_wr_data  (q_wr_data),
    .q_full     (q_full)
  );

  // command queue
  wwh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // token reduction and result output
  wwh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rd_data  (q_rd_data),
    .q_rd_en    (q_rd_en),
    .vocab_size (vocab_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: bench/tb_whitespace_word_hash_tokenizer.sv
// self-checking testbench for the whitespace word hash tokenizer
module tb_whitespace_word_hash_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 27;

  // clock, reset and block ports
  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  wwh_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  wwh_pkg::out_item_t             out_data;
  logic                           cfg_we    = 1'b0;
  logic [1:0]                     cfg_index = wwh_pkg::CFG_VOCAB_SIZE;
  logic [wwh_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  whitespace_word_hash_tokenizer DUT (.*);

  always #5 clk = ~clk;

  // idling controls shared by sender and receiver
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  bit hold_ask      = 1'b0;

  // run statistics
  int faults     = 0;
  int n_requests = 0;
  int n_results  = 0;
  int n_texts    = 0;
  int n_writes   = 0;

  // tokenizer copy: configuration and text state
  logic [22:0] vocab_cfg   = wwh_pkg::VOCAB_RESET;
  logic [15:0] max_cfg     = wwh_pkg::MAX_RESET;
  bit          eos_cfg     = 1'b0;
  logic [31:0] hash_acc    = wwh_pkg::FNV_BASIS;
  bit          word_open   = 1'b0;
  int unsigned text_count  = 0;
  bit          text_capped = 1'b0;

  wwh_pkg::out_item_t step_tokens[$];
  wwh_pkg::out_item_t tokens_due[$];

  // directed stimulus table
  typedef struct {
    bit                  is_cfg;
    wwh_pkg::cfg_index_t reg_sel;
    int unsigned         reg_val;
    wwh_pkg::in_item_t   req;
    bit                  typed;
    wwh_pkg::out_item_t  tok;
  } stim_row_t;

  stim_row_t plan[$];

  function automatic wwh_pkg::in_item_t mk_req(input logic [7:0] b, input bit bv,
                                               input bit eot);
    wwh_pkg::in_item_t r;
    r.text_byte   = b;
    r.byte_valid  = bv;
    r.end_of_text = eot;
    return r;
  endfunction

  function automatic void row_cfg(input wwh_pkg::cfg_index_t sel, input int unsigned val);
    stim_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    r.req     = '0;
    r.typed   = 1'b0;
    r.tok     = '0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void row_req(input logic [7:0] b, input bit bv, input bit eot);
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_sel = wwh_pkg::CFG_VOCAB_SIZE;
    r.reg_val = 0;
    r.req     = mk_req(b, bv, eot);
    r.typed   = 1'b0;
    r.tok     = '0;
    plan.insert(plan.size(), r);
  endfunction

  // request whose single result is known outright
  function automatic void row_tok(input logic [7:0] b, input bit bv, input bit eot,
                                  input logic [21:0] id, input bit valid,
                                  input logic [15:0] cnt, input bit done);
    stim_row_t r;
    r.is_cfg            = 1'b0;
    r.reg_sel           = wwh_pkg::CFG_VOCAB_SIZE;
    r.reg_val           = 0;
    r.req               = mk_req(b, bv, eot);
    r.typed             = 1'b1;
    r.tok.token_id      = id;
    r.tok.token_valid   = valid;
    r.tok.run_last      = 1'b1;
    r.tok.text_done     = done;
    r.tok.token_count   = cnt;
    plan.insert(plan.size(), r);
  endfunction

  // word token from a finished hash, vocabulary clamped to its legal range
  function automatic logic [21:0] word_token(input logic [31:0] h);
    logic [31:0] v;
    v = 32'(vocab_cfg);
    if (v < 32'(wwh_pkg::VOCAB_MIN)) v = 32'(wwh_pkg::VOCAB_MIN);
    if (v > 32'(wwh_pkg::VOCAB_MAX)) v = 32'(wwh_pkg::VOCAB_MAX);
    return 22'(h % (v - 32'(wwh_pkg::WORD_BASE)) + 32'(wwh_pkg::WORD_BASE));
  endfunction

  function automatic void add_token(input logic [21:0] id, input bit valid);
    wwh_pkg::out_item_t t;
    t             = '0;
    t.token_id    = valid ? id : 22'd0;
    t.token_valid = valid;
    t.token_count = text_count[15:0];
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  // tokens caused by one request, left in step_tokens
  function automatic void tokenize_step(input wwh_pkg::in_item_t req);
    int last;
    step_tokens.delete();
    if (req.byte_valid) begin
      if (text_capped || text_count + 1 >= max_cfg) begin
        text_capped = 1'b1;
      end else if (req.text_byte inside {wwh_pkg::BYTE_SPACE, wwh_pkg::BYTE_NL,
                                         wwh_pkg::BYTE_CR, wwh_pkg::BYTE_TAB}) begin
        if (word_open) begin
          text_count++;
          add_token(word_token(hash_acc), 1'b1);
          hash_acc  = wwh_pkg::FNV_BASIS;
          word_open = 1'b0;
        end
        if (req.text_byte == wwh_pkg::BYTE_NL && text_count < max_cfg) begin
          text_count++;
          add_token(wwh_pkg::NL_TOKEN, 1'b1);
        end
      end else begin
        hash_acc  = (hash_acc ^ {24'd0, req.text_byte}) * wwh_pkg::FNV_PRIME;
        word_open = 1'b1;
      end
    end
    if (req.end_of_text) begin
      if (word_open && !text_capped && text_count + 1 < max_cfg) begin
        text_count++;
        add_token(word_token(hash_acc), 1'b1);
      end
      if (eos_cfg && text_count < max_cfg) begin
        text_count++;
        add_token(wwh_pkg::EOS_TOKEN, 1'b1);
      end
      // an end with nothing to say still closes the text
      if (step_tokens.size() == 0) add_token(22'd0, 1'b0);
      last = step_tokens.size() - 1;
      step_tokens[last].text_done = 1'b1;
      hash_acc    = wwh_pkg::FNV_BASIS;
      word_open   = 1'b0;
      text_count  = 0;
      text_capped = 1'b0;
    end
    if (step_tokens.size() != 0) begin
      last = step_tokens.size() - 1;
      step_tokens[last].run_last = 1'b1;
    end
  endfunction

  function automatic void note_fault(input string what, input wwh_pkg::out_item_t want,
                                     input wwh_pkg::out_item_t got);
    faults++;
    if (faults <= 10) begin
      $display("%s at %0t: expected id=%0d v=%0b last=%0b done=%0b cnt=%0d", what, $realtime,
               want.token_id, want.token_valid, want.run_last, want.text_done,
               want.token_count);
      $display("  got id=%0d v=%0b last=%0b done=%0b cnt=%0d", got.token_id,
               got.token_valid, got.run_last, got.text_done, got.token_count);
    end
  endfunction

  // send one request, then predict what it causes
  task automatic offer_request(input wwh_pkg::in_item_t req, input bit typed,
                               input wwh_pkg::out_item_t tok);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    n_requests++;
    tokenize_step(req);
    if (typed) tokens_due.insert(tokens_due.size(), tok);
    else foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
  endtask

  task automatic wait_tokens();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
  endtask

  // idle block: nothing owed and any silent request worked off
  task automatic settle();
    wait_tokens();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input wwh_pkg::cfg_index_t sel, input int unsigned val);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val[wwh_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_writes++;
    case (sel)
      wwh_pkg::CFG_VOCAB_SIZE: vocab_cfg = val[22:0];
      wwh_pkg::CFG_MAX_TOKENS: max_cfg   = val[15:0];
      wwh_pkg::CFG_ADD_EOS:    eos_cfg   = val[0];
      default: ;
    endcase
  endtask

  // random setting; a roomy one keeps the token limit out of the way
  task automatic pick_setting(input bit roomy);
    int unsigned vocab;
    int unsigned limit;
    case ($urandom_range(4))
      0: vocab = $urandom_range(10);
      1: vocab = 11;
      2: vocab = 4194304;
      3: vocab = $urandom_range(8388607, 4194305);
      default: vocab = $urandom_range(70000, 12);
    endcase
    case ($urandom_range(4))
      0: limit = $urandom_range(2);
      1: limit = 65535;
      default: limit = $urandom_range(12, 3);
    endcase
    if (roomy) limit = 65535;
    write_reg(wwh_pkg::CFG_VOCAB_SIZE, vocab);
    write_reg(wwh_pkg::CFG_MAX_TOKENS, limit);
    write_reg(wwh_pkg::CFG_ADD_EOS, $urandom_range(1));
  endtask

  function automatic logic [7:0] pick_word_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b inside {wwh_pkg::BYTE_SPACE, wwh_pkg::BYTE_NL, wwh_pkg::BYTE_CR,
                     wwh_pkg::BYTE_TAB}) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(3))
      0: return wwh_pkg::BYTE_SPACE;
      1: return wwh_pkg::BYTE_NL;
      2: return wwh_pkg::BYTE_CR;
      default: return wwh_pkg::BYTE_TAB;
    endcase
  endfunction

  // one random text, mostly well formed; returns the requests that count
  task automatic random_text(output int used);
    int                shape;
    int                nwords;
    int                len;
    wwh_pkg::in_item_t req;
    used  = 0;
    shape = $urandom_range(9);
    // noise: a lone request with random byte and flags
    if (shape == 0) begin
      req = mk_req(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom_range(3) == 0);
      offer_request(req, 1'b0, '0);
      if (req.byte_valid || req.end_of_text) used = 1;
      return;
    end
    nwords = $urandom_range(4, 1);
    for (int w = 0; w < nwords; w++) begin
      len = $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
        offer_request(mk_req(pick_word_byte(), 1'b1, 1'b0), 1'b0, '0);
        used++;
      end
      if (w < nwords - 1 || shape >= 7) begin
        offer_request(mk_req(pick_separator(), 1'b1, 1'b0), 1'b0, '0);
        used++;
      end
    end
    // broken text: no end, runs on into the next one
    if (shape == 1) return;
    if ($urandom_range(1))
      req = mk_req(8'($urandom_range(255)), 1'b0, 1'b1);
    else
      req = mk_req(8'($urandom_range(255)), 1'b1, 1'b1);
    offer_request(req, 1'b0, '0);
    used++;
  endtask

  // receiver: random stalls plus one long hold on request
  initial begin : token_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_ask) begin
        hold_left = HOLD_CYCLES;
        hold_ask  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin : token_monitor
    wwh_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_data.text_done) n_texts++;
      if (tokens_due.size() == 0) begin
        note_fault("unexpected result", '0, out_data);
      end else begin
        want = tokens_due.pop_front();
        if (out_data.token_id !== want.token_id || out_data.token_valid !== want.token_valid ||
            out_data.run_last !== want.run_last || out_data.text_done !== want.text_done ||
            out_data.token_count !== want.token_count)
          note_fault("result mismatch", want, out_data);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles, %0d results owed", STALL_LIMIT,
             tokens_due.size());
    $display("simulation failed");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    int send_pct[4];
    int stall_pct[4];
    int used;
    int texts;
    int phase_used;
    send_pct  = '{0, 61, 0, 32};
    stall_pct = '{0, 0, 61, 32};

    // directed part at reset settings
    row_tok(wwh_pkg::BYTE_NL, 1'b1, 1'b0, wwh_pkg::NL_TOKEN, 1'b1, 16'd1, 1'b0);
    row_tok(8'h00, 1'b0, 1'b1, 22'd0, 1'b0, 16'd1, 1'b1);
    row_req(8'h55, 1'b0, 1'b0);
    row_req(8'h00, 1'b1, 1'b0);
    row_req(8'hFF, 1'b1, 1'b0);
    row_req(wwh_pkg::BYTE_SPACE, 1'b1, 1'b0);
    row_req(8'h61, 1'b1, 1'b0);
    row_req(wwh_pkg::BYTE_TAB, 1'b1, 1'b0);
    row_req(8'h62, 1'b1, 1'b0);
    row_req(wwh_pkg::BYTE_CR, 1'b1, 1'b0);
    row_req(8'h63, 1'b1, 1'b0);
    row_req(wwh_pkg::BYTE_NL, 1'b1, 1'b0);
    row_req(8'h64, 1'b1, 1'b1);
    row_tok(wwh_pkg::BYTE_SPACE, 1'b1, 1'b1, 22'd0, 1'b0, 16'd0, 1'b1);
    // smallest vocabulary, tight token limit, end token on
    row_cfg(wwh_pkg::CFG_VOCAB_SIZE, 11);
    row_cfg(wwh_pkg::CFG_MAX_TOKENS, 3);
    row_cfg(wwh_pkg::CFG_ADD_EOS, 1);
    row_req(8'h78, 1'b1, 1'b0);
    row_tok(wwh_pkg::BYTE_SPACE, 1'b1, 1'b0, wwh_pkg::WORD_BASE, 1'b1, 16'd1, 1'b0);
    row_req(8'h79, 1'b1, 1'b0);
    row_req(wwh_pkg::BYTE_NL, 1'b1, 1'b0);
    row_req(8'h7A, 1'b1, 1'b0);
    row_tok(8'h00, 1'b0, 1'b1, 22'd0, 1'b0, 16'd3, 1'b1);
    // no tokens allowed at all
    row_cfg(wwh_pkg::CFG_MAX_TOKENS, 0);
    row_tok(8'h71, 1'b1, 1'b1, 22'd0, 1'b0, 16'd0, 1'b1);
    // room for the end token only
    row_cfg(wwh_pkg::CFG_MAX_TOKENS, 1);
    row_tok(8'h00, 1'b0, 1'b1, wwh_pkg::EOS_TOKEN, 1'b1, 16'd1, 1'b1);
    // vocabulary above and at the top, then below the bottom
    row_cfg(wwh_pkg::CFG_VOCAB_SIZE, 8388607);
    row_cfg(wwh_pkg::CFG_MAX_TOKENS, 65535);
    row_req(8'h77, 1'b1, 1'b1);
    row_cfg(wwh_pkg::CFG_VOCAB_SIZE, 4194304);
    row_cfg(wwh_pkg::CFG_ADD_EOS, 0);
    row_req(8'h76, 1'b1, 1'b1);
    row_cfg(wwh_pkg::CFG_VOCAB_SIZE, 5);
    row_tok(8'h75, 1'b1, 1'b1, wwh_pkg::WORD_BASE, 1'b1, 16'd1, 1'b1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    in_idle_pct   = 25;
    out_stall_pct = 25;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_sel, plan[i].reg_val);
      else offer_request(plan[i].req, plan[i].typed, plan[i].tok);
    end

    // random texts under each idling profile
    for (int p = 0; p < 4; p++) begin
      pick_setting(p == 0);
      in_idle_pct   = send_pct[p];
      out_stall_pct = stall_pct[p];
      phase_used    = 0;
      texts         = 0;
      // long receiver hold while requests keep coming
      if (p == 0) hold_ask = 1'b1;
      while (phase_used < PHASE_ITEMS) begin
        random_text(used);
        phase_used += used;
        texts++;
        // sender pause until every token is back
        if (p == 1 && texts == 1) wait_tokens();
      end
    end

    wait_tokens();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tokens_due.size() != 0) begin
      $display("%0d expected results never arrived", tokens_due.size());
      faults += tokens_due.size();
    end

    $display("covered %0d requests, %0d tokens checked over %0d finished texts, %0d reg writes",
             n_requests, n_results, n_texts, n_writes);
    $display("idling: none, sender only, receiver only, both; one long hold, one full drain");
    if (faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
